// ===== src/ts_pmt_section_parser_defines.svh =====
// Assertion macros used by the RTL of ts_pmt_section_parser.
`ifndef TS_PMT_SECTION_PARSER_DEFINES_SVH
`define TS_PMT_SECTION_PARSER_DEFINES_SVH

// Condition in one cycle implies consequence in the same cycle.
`define TSPMT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition in one cycle implies consequence in the next cycle.
`define TSPMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tspmt_pkg.sv =====
package tspmt_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 120;
   localparam int KIND_W     = 3;
   localparam int PHASE_W    = 3;

   localparam logic [7:0] TABLE_ID = 8'h02;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HEADER = 3'd1;
   localparam logic [PHASE_W-1:0] PH_INFO   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_ENTRY  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_ESSKIP = 3'd4;
   localparam logic [PHASE_W-1:0] PH_CRC    = 3'd5;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DONE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_ID  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_LEN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRUNC   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } byte_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        stream_type;
      logic [12:0]       elementary_pid;
      logic [11:0]       es_info_length;
      logic [15:0]       program_number;
      logic [4:0]        version;
      logic              current_next;
      logic [7:0]        section_index;
      logic [7:0]        last_section_index;
      logic [12:0]       pcr_pid;
      logic [31:0]       section_crc;
   } rsp_type;

endpackage

// ===== src/tspmt_in_stage.sv =====
module tspmt_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tspmt_pkg::byte_type req_item,
   input  logic               take,
   output logic               item_valid,
   output tspmt_pkg::byte_type item
);
   import tspmt_pkg::*;

   logic     valid_ff, valid_in;
   byte_type item_ff;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/tspmt_parser.sv =====
module tspmt_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  tspmt_pkg::byte_type item,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output tspmt_pkg::rsp_type  rsp
);
   import tspmt_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         header_index_ff, header_index_in;
   logic [11:0]        section_len_ff, section_len_in;
   logic [11:0]        skip_left_ff, skip_left_in;
   logic [11:0]        streams_left_ff, streams_left_in;
   logic [2:0]         entry_index_ff, entry_index_in;
   logic [7:0]         held_type_ff, held_type_in;
   logic [12:0]        held_pid_ff, held_pid_in;
   logic [11:0]        held_es_len_ff, held_es_len_in;
   logic [15:0]        held_program_ff, held_program_in;
   logic [4:0]         held_version_ff, held_version_in;
   logic               held_current_ff, held_current_in;
   logic [7:0]         held_section_ff, held_section_in;
   logic [7:0]         held_last_section_ff, held_last_section_in;
   logic [12:0]        held_pcr_ff, held_pcr_in;
   logic [31:0]        crc_shift_ff, crc_shift_in;
   logic [7:0]         high_byte_ff, high_byte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [7:0]        b;
   logic [11:0]       len_field;
   logic [12:0]       need;
   logic [12:0]       area;
   logic [11:0]       sl_dec;
   logic [11:0]       sl_left;
   logic [11:0]       skip_dec;
   logic [KIND_W-1:0] ev;
   logic [KIND_W-1:0] out_kind;
   logic              active;
   logic              bad_id;

   assign b         = item.data_byte;
   assign len_field = {high_byte_ff[3:0], b};
   assign need      = 13'd13 + {1'b0, len_field};
   assign area      = {1'b0, section_len_ff} - need;
   assign sl_dec    = streams_left_ff - 12'd1;
   assign sl_left   = sl_dec - len_field;
   assign skip_dec  = (skip_left_ff != 12'd0) ? skip_left_ff - 12'd1 : skip_left_ff;

   always_comb begin
      phase_in             = phase_ff;
      header_index_in      = header_index_ff;
      section_len_in       = section_len_ff;
      skip_left_in         = skip_left_ff;
      streams_left_in      = streams_left_ff;
      entry_index_in       = entry_index_ff;
      held_type_in         = held_type_ff;
      held_pid_in          = held_pid_ff;
      held_es_len_in       = held_es_len_ff;
      held_program_in      = held_program_ff;
      held_version_in      = held_version_ff;
      held_current_in      = held_current_ff;
      held_section_in      = held_section_ff;
      held_last_section_in = held_last_section_ff;
      held_pcr_in          = held_pcr_ff;
      crc_shift_in         = crc_shift_ff;
      high_byte_in         = high_byte_ff;
      ev                   = KIND_NONE;
      active               = 1'b0;
      bad_id               = 1'b0;

      if (step) begin
         if (item.first_byte) begin
            active = 1'b1;
            if (b != TABLE_ID) begin
               bad_id   = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in        = PH_HEADER;
               header_index_in = 4'd0;
            end
         end else begin
            unique case (phase_ff)
               PH_HEADER: begin
                  active          = 1'b1;
                  header_index_in = header_index_ff + 4'd1;
                  unique case (header_index_ff)
                     4'd0: section_len_in = {b[3:0], 8'h00};
                     4'd1: section_len_in = section_len_ff | {4'h0, b};
                     4'd2: held_program_in = {b, 8'h00};
                     4'd3: held_program_in = held_program_ff | {8'h00, b};
                     4'd4: begin
                        held_version_in = b[5:1];
                        held_current_in = b[0];
                     end
                     4'd5: held_section_in = b;
                     4'd6: held_last_section_in = b;
                     4'd7: high_byte_in = b;
                     4'd8: held_pcr_in = {high_byte_ff[4:0], b};
                     4'd9: high_byte_in = b;
                     default: begin
                        // program info length: closes the fixed header
                        header_index_in = header_index_ff;
                        if ({1'b0, section_len_ff} < need) begin
                           ev = KIND_BAD_LEN;
                        end else begin
                           streams_left_in = area[11:0];
                           if (len_field != 12'd0) begin
                              skip_left_in = len_field;
                              phase_in     = PH_INFO;
                           end else begin
                              entry_index_in = 3'd0;
                              phase_in = (area[11:0] != 12'd0) ? PH_ENTRY : PH_CRC;
                           end
                        end
                     end
                  endcase
               end
               PH_INFO, PH_ESSKIP: begin
                  active       = 1'b1;
                  skip_left_in = skip_dec;
                  if (skip_dec == 12'd0) begin
                     entry_index_in = 3'd0;
                     phase_in = (streams_left_ff != 12'd0) ? PH_ENTRY : PH_CRC;
                  end
               end
               PH_ENTRY: begin
                  active = 1'b1;
                  if (streams_left_ff == 12'd0) begin
                     ev = KIND_BAD_LEN;
                  end else begin
                     streams_left_in = sl_dec;
                     entry_index_in  = entry_index_ff + 3'd1;
                     unique case (entry_index_ff)
                        3'd0: held_type_in = b;
                        3'd1: high_byte_in = b;
                        3'd2: held_pid_in = {high_byte_ff[4:0], b};
                        3'd3: high_byte_in = b;
                        default: begin
                           entry_index_in = entry_index_ff;
                           held_es_len_in = len_field;
                           if (len_field > sl_dec) begin
                              ev = KIND_BAD_LEN;
                           end else begin
                              ev              = KIND_ENTRY;
                              streams_left_in = sl_left;
                              if (len_field != 12'd0) begin
                                 skip_left_in = len_field;
                                 phase_in     = PH_ESSKIP;
                              end else begin
                                 entry_index_in = 3'd0;
                                 phase_in = (sl_left != 12'd0) ? PH_ENTRY : PH_CRC;
                              end
                           end
                        end
                     endcase
                  end
               end
               PH_CRC: begin
                  active       = 1'b1;
                  crc_shift_in = {crc_shift_ff[23:0], b};
                  if (entry_index_ff >= 3'd3) begin
                     ev = KIND_DONE;
                  end else begin
                     entry_index_in = entry_index_ff + 3'd1;
                  end
               end
               default: begin
                  // idle: bytes outside a section are dropped
                  active = 1'b0;
               end
            endcase
         end
      end

      out_kind = KIND_NONE;
      priority if (bad_id) begin
         out_kind = KIND_BAD_ID;
      end else if (ev == KIND_DONE || ev == KIND_BAD_LEN) begin
         phase_in = PH_IDLE;
         out_kind = ev;
      end else if (active && item.last_byte) begin
         phase_in = PH_IDLE;
         out_kind = KIND_TRUNC;
      end else if (ev == KIND_ENTRY) begin
         out_kind = KIND_ENTRY;
      end else begin
         out_kind = KIND_NONE;
      end
   end

   always_comb begin
      rsp_in      = '0;
      rsp_in.kind = out_kind;
      if (out_kind == KIND_ENTRY || out_kind == KIND_DONE) begin
         rsp_in.program_number     = held_program_in;
         rsp_in.version            = held_version_in;
         rsp_in.current_next       = held_current_in;
         rsp_in.section_index      = held_section_in;
         rsp_in.last_section_index = held_last_section_in;
         rsp_in.pcr_pid            = held_pcr_in;
      end
      if (out_kind == KIND_ENTRY) begin
         rsp_in.stream_type    = held_type_in;
         rsp_in.elementary_pid = held_pid_in;
         rsp_in.es_info_length = held_es_len_in;
      end
      if (out_kind == KIND_DONE) begin
         rsp_in.section_crc = crc_shift_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_kind != KIND_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         header_index_ff <= 4'd0;
         skip_left_ff    <= 12'd0;
         streams_left_ff <= 12'd0;
         entry_index_ff  <= 3'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         skip_left_ff    <= skip_left_in;
         streams_left_ff <= streams_left_in;
         entry_index_ff  <= entry_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      section_len_ff       <= section_len_in;
      held_type_ff         <= held_type_in;
      held_pid_ff          <= held_pid_in;
      held_es_len_ff       <= held_es_len_in;
      held_program_ff      <= held_program_in;
      held_version_ff      <= held_version_in;
      held_current_ff      <= held_current_in;
      held_section_ff      <= held_section_in;
      held_last_section_ff <= held_last_section_in;
      held_pcr_ff          <= held_pcr_in;
      crc_shift_ff         <= crc_shift_in;
      high_byte_ff         <= high_byte_in;
      if (out_kind != KIND_NONE) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/ts_pmt_section_parser.sv =====
// channel | dir | tdata                 | tuser      | tlast
// req     | in  | data_byte [7:0]       | first_byte | last_byte
// rsp     | out | entry/header/crc 116b | kind [2:0] | -
//
// One byte per clock while rsp is not stalled.
// Bytes pass an input register, the parser state update, then the result register.
// Reset is synchronous; it sends the parser idle and empties both registers.
// A stalled rsp holds its item while one more byte waits in the input register.
`include "ts_pmt_section_parser_defines.svh"

module ts_pmt_section_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tspmt_pkg::REQ_DATA_W-1:0]      req_tdata,  // data_byte
   input  logic                                  req_tuser,  // first_byte
   input  logic                                  req_tlast,  // last_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // stream_type, elementary_pid, es_info_length, program_number, version,
   // current_next, section_index, last_section_index, pcr_pid, section_crc, pad
   output logic [tspmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [tspmt_pkg::KIND_W-1:0]          rsp_tuser   // kind
);
   import tspmt_pkg::*;

   byte_type req_item;
   byte_type item;
   logic     item_valid;
   logic     out_free;
   logic     step;
   rsp_type  rsp;

   assign req_item.data_byte  = req_tdata;
   assign req_item.first_byte = req_tuser;
   assign req_item.last_byte  = req_tlast;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign step     = item_valid && out_free;

   tspmt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   tspmt_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (item),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {4'h0, rsp.section_crc, rsp.pcr_pid, rsp.last_section_index,
                       rsp.section_index, rsp.current_next, rsp.version,
                       rsp.program_number, rsp.es_info_length, rsp.elementary_pid,
                       rsp.stream_type};

   `TSPMT_ASSERT_NEXT(a_bad_id_reported,
      step && item.first_byte && item.data_byte != TABLE_ID,
      rsp_tvalid && rsp_tuser == KIND_BAD_ID,
      "bad table id not reported")

   `TSPMT_ASSERT_NOW(a_error_fields_zero,
      rsp_tvalid && (rsp_tuser == KIND_BAD_ID || rsp_tuser == KIND_BAD_LEN ||
                     rsp_tuser == KIND_TRUNC),
      rsp_tdata == '0,
      "error item carries nonzero fields")

   `TSPMT_ASSERT_NOW(a_stall_only_when_full,
      !req_tready,
      item_valid && !step && rsp_tvalid && !rsp_tready,
      "input stalled without a full pipeline")

endmodule
